// ===== rtl/yrp_pkg.sv =====
`default_nettype none

package yrp_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int MAX_PAIRS     = MAX_DIMENSION / 2;

    localparam int LUMA_W  = 8;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 24;
    localparam int DIM_W   = 13;
    localparam int OFS_W   = 12;
    localparam int COL_W   = $clog2(MAX_PAIRS);
    localparam int ROW_W   = $clog2(MAX_DIMENSION);
    localparam int PAIR_W  = COL_W + 1;
    localparam int ROWS_W  = ROW_W + 1;
    localparam int YPOS_W  = ((OFS_W > ROW_W) ? OFS_W : ROW_W) + 1;
    localparam int COL2_W  = COL_W + 1;
    localparam int DELTA_W = 10;
    localparam int SUM_W   = 11;
    localparam int CHR_W   = 9;
    localparam int COEF_W  = 10;
    localparam int PROD_W  = CHR_W + COEF_W;
    localparam int FRAC_W  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic signed [COEF_W-1:0] COEF_RV = 10'sd359;
    localparam logic signed [COEF_W-1:0] COEF_GU = 10'sd88;
    localparam logic signed [COEF_W-1:0] COEF_GV = 10'sd183;
    localparam logic signed [COEF_W-1:0] COEF_BU = 10'sd454;
    localparam logic [CHR_W-1:0]         CHROMA_OFS = 9'd128;
    localparam logic [LUMA_W-1:0]        CHAN_MAX   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_WIDTH  = 3'd0,
        CFG_CAMERA_HEIGHT = 3'd1,
        CFG_SCREEN_WIDTH  = 3'd2,
        CFG_OFFSET_X      = 3'd3,
        CFG_OFFSET_Y      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] camera_width;
        logic [DIM_W-1:0] camera_height;
        logic [DIM_W-1:0] screen_width;
        logic [OFS_W-1:0] offset_x;
        logic [OFS_W-1:0] offset_y;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        camera_width:  13'd640,
        camera_height: 13'd480,
        screen_width:  13'd1024,
        offset_x:      12'd192,
        offset_y:      12'd60
    };

    typedef struct packed {
        logic signed [DELTA_W-1:0] dr;
        logic signed [DELTA_W-1:0] dg;
        logic signed [DELTA_W-1:0] db;
    } chroma_delta_t;

    function automatic logic [LUMA_W-1:0] clamp8(input logic signed [SUM_W-1:0] x);
        logic [LUMA_W-1:0] r;
        if (x[SUM_W-1])
            r = '0;
        else if (|x[SUM_W-2:LUMA_W])
            r = CHAN_MAX;
        else
            r = x[LUMA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/yrp_if.sv =====
`default_nettype none

interface yrp_yuyv_if
    import yrp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] luma_first;
    logic [LUMA_W-1:0] chroma_blue;
    logic [LUMA_W-1:0] luma_second;
    logic [LUMA_W-1:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                    output ready);
endinterface

interface yrp_rgb_if
    import yrp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pixel_first;
    logic [PIX_W-1:0]  pixel_second;
    logic [ADDR_W-1:0] write_address;
    logic              frame_last;

    modport source (output valid, pixel_first, pixel_second, write_address, frame_last,
                    input ready);
    modport sink   (input valid, pixel_first, pixel_second, write_address, frame_last,
                    output ready);
endinterface

interface yrp_cfg_if
    import yrp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/yrp_chroma.sv =====
`default_nettype none

module yrp_chroma
    import yrp_pkg::*;
(
    input  wire logic [LUMA_W-1:0] chroma_blue,
    input  wire logic [LUMA_W-1:0] chroma_red,
    output chroma_delta_t          delta
);

    logic signed [CHR_W-1:0]  u_s;
    logic signed [CHR_W-1:0]  v_s;
    logic signed [PROD_W-1:0] prod_rv;
    logic signed [PROD_W-1:0] prod_gu;
    logic signed [PROD_W-1:0] prod_gv;
    logic signed [PROD_W-1:0] prod_bu;
    logic signed [PROD_W-1:0] green_sum;

    always_comb
    begin
        u_s = $signed(CHR_W'(chroma_blue) - CHROMA_OFS);
        v_s = $signed(CHR_W'(chroma_red) - CHROMA_OFS);
        prod_rv = PROD_W'(v_s) * PROD_W'(COEF_RV);
        prod_gu = PROD_W'(u_s) * PROD_W'(COEF_GU);
        prod_gv = PROD_W'(v_s) * PROD_W'(COEF_GV);
        prod_bu = PROD_W'(u_s) * PROD_W'(COEF_BU);
        // arithmetic shift gives the floor of the fixed-point product
        green_sum = -(prod_gu >>> FRAC_W) - (prod_gv >>> FRAC_W);
        delta.dr = DELTA_W'(prod_rv >>> FRAC_W);
        delta.dg = DELTA_W'(green_sum);
        delta.db = DELTA_W'(prod_bu >>> FRAC_W);
    end

endmodule

`default_nettype wire

// ===== rtl/yrp_lane.sv =====
`default_nettype none

module yrp_lane
    import yrp_pkg::*;
(
    input  wire logic [LUMA_W-1:0] luma,
    input  wire chroma_delta_t     delta,
    output logic [PIX_W-1:0]       pixel
);

    logic signed [SUM_W-1:0] luma_s;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;
    logic [LUMA_W-1:0]       red;
    logic [LUMA_W-1:0]       green;
    logic [LUMA_W-1:0]       blue;

    always_comb
    begin
        luma_s = $signed(SUM_W'(luma));
        sum_r  = luma_s + SUM_W'(delta.dr);
        sum_g  = luma_s + SUM_W'(delta.dg);
        sum_b  = luma_s + SUM_W'(delta.db);
        red    = clamp8(sum_r);
        green  = clamp8(sum_g);
        blue   = clamp8(sum_b);
        pixel  = {red[7:3], green[7:2], blue[7:3]};
    end

endmodule

`default_nettype wire

// ===== rtl/yrp_place.sv =====
`default_nettype none

module yrp_place
    import yrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_regs_t   cfg_regs,
    input  wire logic        accept,
    input  wire logic        advance,
    output logic [ADDR_W-1:0] address,
    output logic             frame_last
);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic [YPOS_W-1:0] ypos_s1_reg;
    logic [COL2_W-1:0] col2_s1_reg;
    logic              last_s1_reg;
    logic [ADDR_W-1:0] prod_s2_reg;
    logic [COL2_W-1:0] col2_s2_reg;
    logic              last_s2_reg;

    logic [DIM_W-1:0]  pairs_raw;
    logic [PAIR_W-1:0] pairs;
    logic [ROWS_W-1:0] rows;
    logic              last_col;
    logic              last_row;
    logic [YPOS_W-1:0] ypos;

    always_comb
    begin
        pairs_raw = cfg_regs.camera_width >> 1;
        priority if (pairs_raw == '0)
            pairs = PAIR_W'(1);
        else if (pairs_raw > DIM_W'(MAX_PAIRS))
            pairs = PAIR_W'(MAX_PAIRS);
        else
            pairs = PAIR_W'(pairs_raw);

        priority if (cfg_regs.camera_height == '0)
            rows = ROWS_W'(1);
        else if (cfg_regs.camera_height > DIM_W'(MAX_DIMENSION))
            rows = ROWS_W'(MAX_DIMENSION);
        else
            rows = ROWS_W'(cfg_regs.camera_height);

        // a counter left past a shrunken bound counts as last and wraps
        last_col = (PAIR_W'(col_reg) + PAIR_W'(1)) >= pairs;
        last_row = (ROWS_W'(row_reg) + ROWS_W'(1)) >= rows;
        ypos     = YPOS_W'(cfg_regs.offset_y) + YPOS_W'(row_reg);

        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ypos_s1_reg <= ypos;
            col2_s1_reg <= {col_reg, 1'b0};
            last_s1_reg <= last_col && last_row;
        end
        if (advance)
        begin
            prod_s2_reg <= ADDR_W'(ypos_s1_reg) * ADDR_W'(cfg_regs.screen_width);
            col2_s2_reg <= col2_s1_reg;
            last_s2_reg <= last_s1_reg;
        end
    end

    assign address    = prod_s2_reg + ADDR_W'(cfg_regs.offset_x) + ADDR_W'(col2_s2_reg);
    assign frame_last = last_s2_reg;

endmodule

`default_nettype wire

// ===== rtl/yuyv_to_rgb565_placer_core.sv =====
// An accepted beat is registered in stage 1, in stage 2 and in the output register.
// Throughput: one macropixel per clock unless the output stalls; two lanes convert both
// luma samples in parallel, and the address path holds one 13x13 multiply stage.
// Input ready drops only while the output beat is held and both inner stages are full.
// Reset (rst_n low, asynchronous) empties the pipeline, zeroes the row and
// column counters and restores the default frame geometry registers.
`default_nettype none

module yuyv_to_rgb565_placer_core
    import yrp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    yrp_yuyv_if.sink    yuyv,
    yrp_rgb_if.source   rgb,
    yrp_cfg_if.sink     cfg
);

    cfg_regs_t         cfg_reg;

    logic              v1_reg;
    logic              v1_next;
    logic              v2_reg;
    logic              v2_next;
    logic              vo_reg;
    logic              vo_next;
    logic              can_out;
    logic              can2;
    logic              can1;
    logic              accept;

    logic [LUMA_W-1:0] y0_s1_reg;
    logic [LUMA_W-1:0] y1_s1_reg;
    logic [LUMA_W-1:0] cb_s1_reg;
    logic [LUMA_W-1:0] cr_s1_reg;
    logic [LUMA_W-1:0] y0_s2_reg;
    logic [LUMA_W-1:0] y1_s2_reg;
    chroma_delta_t     delta_s2_reg;
    chroma_delta_t     delta_s1;

    logic [PIX_W-1:0]  pix0;
    logic [PIX_W-1:0]  pix1;
    logic [ADDR_W-1:0] address;
    logic              frame_last;
    logic [PIX_W-1:0]  pix0_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              last_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_CAMERA_WIDTH:  cfg_reg.camera_width  <= cfg.data;
                CFG_CAMERA_HEIGHT: cfg_reg.camera_height <= cfg.data;
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg.data;
                CFG_OFFSET_X:      cfg_reg.offset_x      <= cfg.data[OFS_W-1:0];
                CFG_OFFSET_Y:      cfg_reg.offset_y      <= cfg.data[OFS_W-1:0];
                default:           ;
            endcase
        end
    end

    // stage flow: a stage loads when it is empty or the next one moves
    always_comb
    begin
        can_out = !vo_reg || rgb.ready;
        can2    = !v2_reg || can_out;
        can1    = !v1_reg || can2;
        accept  = yuyv.valid && can1;
        v1_next = can1 ? yuyv.valid : v1_reg;
        v2_next = can2 ? v1_reg : v2_reg;
        vo_next = can_out ? v2_reg : vo_reg;
    end

    assign yuyv.ready = can1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    yrp_chroma u_chroma (
        .chroma_blue (cb_s1_reg),
        .chroma_red  (cr_s1_reg),
        .delta       (delta_s1)
    );

    yrp_lane u_lane0 (
        .luma  (y0_s2_reg),
        .delta (delta_s2_reg),
        .pixel (pix0)
    );

    yrp_lane u_lane1 (
        .luma  (y1_s2_reg),
        .delta (delta_s2_reg),
        .pixel (pix1)
    );

    yrp_place u_place (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_reg),
        .accept     (accept),
        .advance    (can2),
        .address    (address),
        .frame_last (frame_last)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y0_s1_reg <= yuyv.luma_first;
            y1_s1_reg <= yuyv.luma_second;
            cb_s1_reg <= yuyv.chroma_blue;
            cr_s1_reg <= yuyv.chroma_red;
        end
        if (can2)
        begin
            y0_s2_reg    <= y0_s1_reg;
            y1_s2_reg    <= y1_s1_reg;
            delta_s2_reg <= delta_s1;
        end
        // merge both lanes with the placement into one output beat
        if (can_out)
        begin
            pix0_reg <= pix0;
            pix1_reg <= pix1;
            addr_reg <= address;
            last_reg <= frame_last;
        end
    end

    assign rgb.valid         = vo_reg;
    assign rgb.pixel_first   = pix0_reg;
    assign rgb.pixel_second  = pix1_reg;
    assign rgb.write_address = addr_reg;
    assign rgb.frame_last    = last_reg;

endmodule

`default_nettype wire

// ===== rtl/yrp_core_checker.sv =====
`default_nettype none

module yrp_core_checker
    import yrp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [PIX_W-1:0]  out_pixel_first,
    input wire logic [PIX_W-1:0]  out_pixel_second,
    input wire logic [ADDR_W-1:0] out_write_address,
    input wire logic              out_frame_last,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready
);

    // a held output beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel_first)
            && $stable(out_pixel_second) && $stable(out_write_address)
            && $stable(out_frame_last))
        else $error("output beat changed while stalled");

    // with the output free, the pipeline always takes a new beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled although output is free");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write not taken");

    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind yuyv_to_rgb565_placer_core yrp_core_checker u_yrp_core_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (yuyv.valid),
    .in_ready          (yuyv.ready),
    .out_valid         (rgb.valid),
    .out_ready         (rgb.ready),
    .out_pixel_first   (rgb.pixel_first),
    .out_pixel_second  (rgb.pixel_second),
    .out_write_address (rgb.write_address),
    .out_frame_last    (rgb.frame_last),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready)
);

`default_nettype wire
